// ----- src/sdscf_pkg.sv -----
`default_nettype none

package sdscf_pkg;

    // Request codes on the input channel.
    localparam logic REQ_CMD = 1'b0;
    localparam logic REQ_RX  = 1'b1;

    // Result kinds on the output channel.
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_R1   = 2'd1;
    localparam logic [1:0] KIND_BUSY = 2'd2;

    // Frame constants.
    localparam logic [1:0] CMD_START_BITS  = 2'b01;
    localparam logic [7:0] NO_CRC_BYTE     = 8'hFF;
    localparam logic [7:0] STUFF_BYTE      = 8'hFF;
    localparam logic [6:0] CRC7_POLY       = 7'h09;
    localparam logic [7:0] POLL_LIMIT_INIT = 8'd10;

    // Byte positions inside a command frame.
    localparam logic [2:0] POS_START = 3'd0;
    localparam logic [2:0] POS_ARG3  = 3'd1;
    localparam logic [2:0] POS_ARG2  = 3'd2;
    localparam logic [2:0] POS_ARG1  = 3'd3;
    localparam logic [2:0] POS_ARG0  = 3'd4;
    localparam logic [2:0] POS_CRC   = 3'd5;
    localparam logic [2:0] POS_STUFF = 3'd6;

    // Job queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        is_cmd;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_argument;
        logic        use_crc;
        logic        add_stuff_byte;
        logic [1:0]  kind;
        logic [6:0]  r1_status;
    } t_job;

    // One byte of the CRC-7 shift register, most significant bit first.
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in,
                                             input logic [7:0] data);
        logic [6:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 7; i >= 0; i--) begin
            fb  = data[i] ^ crc[6];
            crc = {crc[5:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC7_POLY;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ----- src/sdscf_front.sv -----
`default_nettype none

module sdscf_front
    import sdscf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_accept,
    input  wire logic        i_req_type,
    input  wire logic [5:0]  i_cmd_index,
    input  wire logic [31:0] i_cmd_argument,
    input  wire logic        i_use_crc,
    input  wire logic        i_add_stuff_byte,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_push,
    output t_job             o_job
);

    logic       r_armed, n_armed;
    logic [7:0] r_remaining, n_remaining;
    logic [7:0] r_limit, n_limit;

    always_comb begin
        n_armed     = r_armed;
        n_remaining = r_remaining;
        n_limit     = i_cfg_we ? i_cfg_data : r_limit;
        o_push      = 1'b0;
        o_job       = '0;
        if (i_accept) begin
            if (i_req_type == REQ_CMD) begin
                o_push               = 1'b1;
                o_job.is_cmd         = 1'b1;
                o_job.cmd_index      = i_cmd_index;
                o_job.cmd_argument   = i_cmd_argument;
                o_job.use_crc        = i_use_crc;
                o_job.add_stuff_byte = i_add_stuff_byte;
                o_job.kind           = KIND_TX;
                n_armed              = 1'b1;
                // A limit of zero behaves as a limit of one.
                n_remaining          = (r_limit == 8'd0) ? 8'd1 : r_limit;
            end else if (r_armed) begin
                if (!i_rx_byte[7]) begin
                    o_push          = 1'b1;
                    o_job.kind      = KIND_R1;
                    o_job.r1_status = i_rx_byte[6:0];
                    n_armed         = 1'b0;
                    n_remaining     = 8'd0;
                end else if (r_remaining <= 8'd1) begin
                    o_push      = 1'b1;
                    o_job.kind  = KIND_BUSY;
                    n_armed     = 1'b0;
                    n_remaining = 8'd0;
                end else begin
                    n_remaining = r_remaining - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_remaining <= 8'd0;
            r_limit     <= POLL_LIMIT_INIT;
        end else begin
            r_armed     <= n_armed;
            r_remaining <= n_remaining;
            r_limit     <= n_limit;
        end
    end

endmodule

`default_nettype wire

// ----- src/sdscf_queue.sv -----
`default_nettype none

module sdscf_queue
    import sdscf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_push_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_head_valid,
    output t_job      o_head_job
);

    t_job              r_slots [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_job   = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/sdscf_back.sv -----
`default_nettype none

module sdscf_back
    import sdscf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_head_valid,
    input  wire t_job  i_head_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_tx_byte,
    output logic [6:0] o_r1_status,
    output logic       o_last
);

    logic [2:0] r_pos;
    logic [6:0] r_crc;
    logic       advance;
    logic [7:0] frame_byte;
    logic       frame_last;

    assign advance = i_head_valid && (!o_out_valid || i_out_ready);

    always_comb begin
        case (r_pos)
            POS_START: frame_byte = {CMD_START_BITS, i_head_job.cmd_index};
            POS_ARG3:  frame_byte = i_head_job.cmd_argument[31:24];
            POS_ARG2:  frame_byte = i_head_job.cmd_argument[23:16];
            POS_ARG1:  frame_byte = i_head_job.cmd_argument[15:8];
            POS_ARG0:  frame_byte = i_head_job.cmd_argument[7:0];
            POS_CRC:   frame_byte = i_head_job.use_crc ? {r_crc, 1'b1} : NO_CRC_BYTE;
            default:   frame_byte = STUFF_BYTE;
        endcase
    end

    assign frame_last = (r_pos == POS_STUFF) ||
                        ((r_pos == POS_CRC) && !i_head_job.add_stuff_byte);

    assign o_pop = advance && (!i_head_job.is_cmd || frame_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_START;
            r_crc       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                o_out_valid <= 1'b1;
                if (i_head_job.is_cmd) begin
                    o_result_kind <= KIND_TX;
                    o_tx_byte     <= frame_byte;
                    o_r1_status   <= '0;
                    o_last        <= frame_last;
                    if (frame_last) begin
                        r_pos <= POS_START;
                        r_crc <= '0;
                    end else begin
                        r_pos <= r_pos + 3'd1;
                        if (r_pos < POS_CRC) begin
                            r_crc <= crc7_byte(r_crc, frame_byte);
                        end
                    end
                end else begin
                    o_result_kind <= i_head_job.kind;
                    o_tx_byte     <= '0;
                    o_r1_status   <= i_head_job.r1_status;
                    o_last        <= 1'b1;
                end
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/sd_spi_command_framer_unit.sv -----
`default_nettype none

// SPI-mode SD command framer with R1 response poll, host side.
//
// Input channel (i_in_valid / o_in_ready): a transfer either issues a command
// (i_req_type low) or hands over one byte read back from the card. A command
// yields six frame bytes, start byte, four argument bytes and the CRC byte,
// plus an optional 0xFF stuff byte, and arms a response poll. A received byte
// with bit 7 clear ends the poll with an R1 result; after the configured
// number of bytes with bit 7 set the poll ends with a busy result. Received
// bytes with no poll armed give no result. o_last marks the final result of
// each input transfer.
// Output channel (o_out_valid / i_out_ready): one result per frame byte of a
// command and one per ended poll. The first result passes through the job
// queue and the output register before it is valid. The back end emits one
// result per cycle while the receiver takes them, so a command occupies it
// for six or seven results and a poll result for one; the front accepts a new
// transfer every cycle while the two-entry job queue has room.
// i_cfg_we writes the poll limit (reset value 10, zero acts as one).
// Reset clears the poll, the queue and the output valid flag and restores the
// poll limit. When the receiver stalls, the output register holds its result,
// the queue fills, and o_in_ready then drops until the back end drains it.
module sd_spi_command_framer_unit
    import sdscf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [5:0]  i_cmd_index,
    input  wire logic [31:0] i_cmd_argument,
    input  wire logic        i_use_crc,
    input  wire logic        i_add_stuff_byte,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_tx_byte,
    output logic [6:0]       o_r1_status,
    output logic             o_last
);

    logic w_accept;
    logic w_push;
    t_job w_push_job;
    logic w_full;
    logic w_pop;
    logic w_head_valid;
    t_job w_head_job;

    // The front only needs queue room; it never waits on the output side.
    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    sdscf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (w_accept),
        .i_req_type       (i_req_type),
        .i_cmd_index      (i_cmd_index),
        .i_cmd_argument   (i_cmd_argument),
        .i_use_crc        (i_use_crc),
        .i_add_stuff_byte (i_add_stuff_byte),
        .i_rx_byte        (i_rx_byte),
        .o_push           (w_push),
        .o_job            (w_push_job)
    );

    sdscf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_job   (w_push_job),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head_job   (w_head_job)
    );

    sdscf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_head_valid),
        .i_head_job    (w_head_job),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_tx_byte     (o_tx_byte),
        .o_r1_status   (o_r1_status),
        .o_last        (o_last)
    );

    // The queue is never written while it is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job queue overflow");

    // Retiring a job always loads the final result of that job.
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_out_valid && o_last))
        else $error("job retired without its final result");

    // Poll results are single and carry no transmit byte.
    a_poll_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind != KIND_TX)) |-> (o_last && (o_tx_byte == 8'd0)))
        else $error("malformed poll result");

    // A busy result carries no status bits.
    a_busy_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == KIND_BUSY)) |-> (o_r1_status == 7'd0))
        else $error("busy result with status bits");

endmodule

`default_nettype wire
